// ----- hw/rtl/jbh_pkg.sv -----
// Shared types, lane codes and the lookup2 mix function for the buffer hash.
// Used by every module of the jenkins_buffer_hash_core block; depends on nothing.
package jbh_pkg;

    localparam logic [31:0] HASH_MAGIC = 32'h9e37_79b9;
    localparam int          GROUP_BYTES = 12;
    localparam int          WORD_BYTES  = 4;

    localparam logic [1:0] LANE_A      = 2'd0;
    localparam logic [1:0] LANE_B      = 2'd1;
    localparam logic [1:0] LANE_C      = 2'd2;
    localparam logic [1:0] LANE_UNUSED = 2'd3;

    localparam logic [2:0] FULL_COUNT = 3'(WORD_BYTES);

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  count;
        logic        last;
    } item_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } acc_t;

    // The published lookup2 mix: nine subtract, subtract and xor steps.
    function automatic acc_t jbh_mix(input acc_t s);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        acc_t        r;
        a = s.a;
        b = s.b;
        c = s.c;
        a = a - b - c; a = a ^ (c >> 13);
        b = b - c - a; b = b ^ (a << 8);
        c = c - a - b; c = c ^ (b >> 13);
        a = a - b - c; a = a ^ (c >> 12);
        b = b - c - a; b = b ^ (a << 16);
        c = c - a - b; c = c ^ (b >> 5);
        a = a - b - c; a = a ^ (c >> 3);
        b = b - c - a; b = b ^ (a << 10);
        c = c - a - b; c = c ^ (b >> 15);
        r.a = a;
        r.b = b;
        r.c = c;
        return r;
    endfunction

endpackage

// ----- hw/rtl/jbh_in_stage.sv -----
// Input register of the buffer hash: holds one accepted word beat.
// Depends on jbh_pkg for the item type.
module jbh_in_stage
    import jbh_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  accept,
    input  item_t item_in,
    input  logic  fire,
    output logic  valid,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_in;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

// ----- hw/rtl/jbh_acc.sv -----
// Accumulator datapath of the buffer hash: seed register, lanes a, b, c,
// lane index and the group and final mixes. Depends on jbh_pkg.
module jbh_acc
    import jbh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        seed_we,
    input  logic [31:0] seed_data,
    input  logic        fire,
    input  item_t       item,
    output logic        res_valid,
    output logic [31:0] res_hash,
    output logic [1:0]  lane
);

    logic [31:0] seed_reg;
    acc_t        acc_reg;
    acc_t        acc_next;
    logic [1:0]  lane_reg;
    logic [1:0]  lane_next;

    logic [1:0]  cur_lane;
    logic [2:0]  count;
    logic [31:0] mask;
    logic [31:0] addend;
    acc_t        summed;
    acc_t        grp_mix;
    acc_t        fin_base;
    acc_t        fin;
    logic        wrap;
    logic [3:0]  rem;

    always_comb
    begin
        cur_lane = (lane_reg == LANE_UNUSED) ? LANE_A : lane_reg;
        count    = (item.count > FULL_COUNT) ? FULL_COUNT : item.count;

        case (count)
            3'd0:    mask = 32'h0000_0000;
            3'd1:    mask = 32'h0000_00ff;
            3'd2:    mask = 32'h0000_ffff;
            3'd3:    mask = 32'h00ff_ffff;
            default: mask = 32'hffff_ffff;
        endcase

        // A word that is not last always contributes all four bytes.
        addend = item.last ? (item.word & mask) : item.word;

        summed = acc_reg;
        case (cur_lane)
            LANE_B:  summed.b = acc_reg.b + addend;
            LANE_C:  summed.c = acc_reg.c + addend;
            default: summed.a = acc_reg.a + addend;
        endcase

        grp_mix = jbh_mix(summed);
        wrap    = (cur_lane == LANE_C) && (!item.last || (count == FULL_COUNT));

        // A last word that closes a group is mixed twice, with nothing left over.
        fin_base   = wrap ? grp_mix : summed;
        rem        = wrap ? 4'd0 : ({cur_lane, 2'b00} + {1'b0, count});
        fin_base.c = fin_base.c + {28'd0, rem};
        fin        = jbh_mix(fin_base);
    end

    always_comb
    begin
        acc_next  = acc_reg;
        lane_next = lane_reg;
        if (seed_we)
        begin
            acc_next  = '{a: seed_data, b: seed_data, c: seed_data};
            lane_next = LANE_A;
        end
        else if (fire)
        begin
            if (item.last)
            begin
                acc_next  = '{a: seed_reg, b: seed_reg, c: seed_reg};
                lane_next = LANE_A;
            end
            else if (wrap)
            begin
                acc_next  = grp_mix;
                lane_next = LANE_A;
            end
            else
            begin
                acc_next  = summed;
                lane_next = (cur_lane == LANE_B) ? LANE_C : LANE_B;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= HASH_MAGIC;
            acc_reg  <= '{a: HASH_MAGIC, b: HASH_MAGIC, c: HASH_MAGIC};
            lane_reg <= LANE_A;
        end
        else
        begin
            if (seed_we)
            begin
                seed_reg <= seed_data;
            end
            acc_reg  <= acc_next;
            lane_reg <= lane_next;
        end
    end

    assign res_valid = fire && item.last;
    assign res_hash  = fin.c;
    assign lane      = lane_reg;

endmodule

// ----- hw/rtl/jbh_out_stage.sv -----
// Result register of the buffer hash: holds one hash beat until taken.
// Depends on jbh_pkg only through the shared import convention.
module jbh_out_stage
    import jbh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  logic [31:0] load_hash,
    input  logic        stall,
    output logic        ready,
    output logic        valid,
    output logic [31:0] hash
);

    logic        valid_reg;
    logic [31:0] hash_reg;

    assign ready = !valid_reg || !stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && load)
        begin
            hash_reg <= load_hash;
        end
    end

    assign valid = valid_reg;
    assign hash  = hash_reg;

endmodule

// ----- hw/rtl/jenkins_buffer_hash_core.sv -----
// Top level of the streaming lookup2-style buffer hash.
// Depends on jbh_pkg, jbh_in_stage, jbh_acc and jbh_out_stage.
//
// Usage: message words enter on the word channel (data_word, byte_count,
// last) with word_valid and word_stall; a beat is taken at a rising edge
// where word_valid is high and word_stall is low. Each beat marked last
// produces one beat on the hash channel (hash_valid, hash_stall, hash).
// A last word waits in the input register until the result register is free
// to load its hash. Throughput: one word per cycle unless a last word waits.
// The cycle time is set by the final hash path, which chains the lane add and
// up to two lookup2 mixes. The user writes the seed register through seed_we
// and seed_data only while the block is idle; the block does not enforce it.
// A write restarts the accumulators from the new seed. Reset loads the seed
// 0x9e3779b9 into all three lanes and empties both the input and the result
// register. When the receiver stalls, the result register holds its beat;
// words that are not last keep flowing, and a last word waits in the input
// register, which raises word_stall.
module jenkins_buffer_hash_core
    import jbh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        seed_we,
    input  logic [31:0] seed_data,
    input  logic        word_valid,
    output logic        word_stall,
    input  logic [31:0] data_word,
    input  logic [2:0]  byte_count,
    input  logic        last,
    output logic        hash_valid,
    input  logic        hash_stall,
    output logic [31:0] hash
);

    item_t       item_in;
    item_t       s1_item;
    logic        s1_valid;
    logic        fire;
    logic        accept;
    logic        out_ready;
    logic        res_valid;
    logic [31:0] res_hash;
    logic [1:0]  lane;

    assign item_in = '{word: data_word, count: byte_count, last: last};

    // A word that is not last never waits; a last one needs room for its hash.
    assign fire       = s1_valid && (!s1_item.last || out_ready);
    assign word_stall = s1_valid && !fire;
    assign accept     = word_valid && !word_stall;

    jbh_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .item_in (item_in),
        .fire    (fire),
        .valid   (s1_valid),
        .item    (s1_item)
    );

    jbh_acc u_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .seed_we   (seed_we),
        .seed_data (seed_data),
        .fire      (fire),
        .item      (s1_item),
        .res_valid (res_valid),
        .res_hash  (res_hash),
        .lane      (lane)
    );

    jbh_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .load_hash (res_hash),
        .stall     (hash_stall),
        .ready     (out_ready),
        .valid     (hash_valid),
        .hash      (hash)
    );

    // A new hash beat appears only after a last word has left the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(hash_valid) |-> $past(fire && s1_item.last))
        else $error("hash beat without a last word");

    // Holding off the sender means a stalled hash beat is still pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        word_stall |=> hash_valid)
        else $error("word channel stalled with no pending hash");

    // A seed write or the end of a message leaves the lane index at lane a.
    assert property (@(posedge clk) disable iff (!rst_n)
        (seed_we || res_valid) |=> (lane == LANE_A))
        else $error("lane index not restarted");

    // The lane index never reaches the unused code.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (lane != LANE_UNUSED))
        else $error("lane index reached the unused code");

endmodule
